// ===== design/rlp_list_element_splitter_macros.svh =====
`ifndef RLP_LIST_ELEMENT_SPLITTER_MACROS_SVH
`define RLP_LIST_ELEMENT_SPLITTER_MACROS_SVH

// Check a property on every rising edge outside reset.
`define RLP_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rlp: %s failed", "name");

// Check that an expression never holds outside reset.
`define RLP_ASSERT_NEVER(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("rlp: %s failed", "name");

`endif

// ===== design/rlp_pkg.sv =====
package rlp_pkg;

  localparam int unsigned LengthWidthDefault = 32;
  localparam logic [2:0]  MaxLenBytesReset   = 3'd4;
  localparam logic [7:0]  OfsString          = 8'd128;
  localparam logic [7:0]  OfsList            = 8'd192;
  localparam logic [5:0]  ShortMax           = 6'd55;
  localparam logic [15:0] IndexMax           = 16'hFFFF;

  localparam logic RegMaxLenBytes = 1'b0;

  typedef enum logic [2:0] {
    PhIdle,
    PhOuterLen,
    PhHdr,
    PhElemLen,
    PhPayload,
    PhDone,
    PhError
  } phase_e;

  typedef enum logic [2:0] {
    RoleOuter  = 3'd0,
    RoleEhdr   = 3'd1,
    RolePay    = 3'd2,
    RoleSingle = 3'd3,
    RoleBeyond = 3'd4,
    RoleErr    = 3'd5
  } role_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } req_t;

  typedef struct packed {
    role_e       byte_role;
    logic [15:0] element_index;
    logic        element_is_list;
    logic [31:0] element_length;
    logic        element_first;
    logic        element_last;
    logic        list_done;
    logic        error_flag;
    logic [7:0]  byte_echo;
  } res_t;

endpackage

// ===== design/rlp_list_element_splitter.sv =====
// Channel  Signals                              Payload
// input    in_valid_i / in_ready_o / in_req_i   data_byte, frame_start
// output   out_valid_o / out_ready_i / out_res_o role, index, kind, length, marks
// config   psel penable pwrite paddr pwdata     max_length_bytes at byte 0
//
// One request per cycle sustained while the output queue has room.
// The input register feeds the parser; its state updates as the result enters
// a two-entry output queue, which sets the rate when the consumer stalls.
// Reset clears the parser to idle and max_length_bytes to 4.
// in_ready_o stays high while the queue has room or the input register is empty.
`include "rlp_list_element_splitter_macros.svh"

module rlp_list_element_splitter import rlp_pkg::*; #(
  parameter int unsigned LENGTH_WIDTH = LengthWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  req_t        in_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output res_t        out_res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [2:0] max_len_q;
  logic       stage_valid_q;
  req_t       stage_req_q;
  logic       space, advance, pop;
  res_t       res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegMaxLenBytes) ? {29'd0, max_len_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenBytesReset;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegMaxLenBytes) begin
      max_len_q <= pwdata[2:0];
    end
  end

  assign advance    = stage_valid_q && space;
  assign in_ready_o = !stage_valid_q || advance;
  assign pop        = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      stage_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      stage_req_q <= in_req_i;
    end
  end

  rlp_parser #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_parser (
    .clk_i,
    .rst_ni,
    .advance_i      (advance),
    .req_i          (stage_req_q),
    .max_len_bytes_i(max_len_q),
    .res_o          (res)
  );

  rlp_out_fifo u_out_fifo (
    .clk_i,
    .rst_ni,
    .push_i (advance),
    .data_i (res),
    .space_o(space),
    .valid_o(out_valid_o),
    .pop_i  (pop),
    .data_o (out_res_o)
  );

  `RLP_ASSERT(a_err_role, clk_i, rst_ni, out_valid_o |-> (out_res_o.error_flag == (out_res_o.byte_role == RoleErr)))
  `RLP_ASSERT(a_done_mark, clk_i, rst_ni, (out_valid_o && out_res_o.list_done) |-> (out_res_o.element_last || out_res_o.byte_role == RoleOuter))
  `RLP_ASSERT_NEVER(a_stall_empty, clk_i, rst_ni, !in_ready_o && !(stage_valid_q && !space))

endmodule

// ===== design/rlp_parser.sv =====
module rlp_parser import rlp_pkg::*; #(
  parameter int unsigned LENGTH_WIDTH = LengthWidthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       advance_i,
  input  req_t       req_i,
  input  logic [2:0] max_len_bytes_i,
  output res_t       res_o
);

  localparam int unsigned LenBytes = LENGTH_WIDTH / 8;
  localparam logic [3:0]  LenBytesW = 4'(LenBytes);

  phase_e                  phase_q, phase_d;
  logic [LENGTH_WIDTH-1:0] orem_q, orem_d;
  logic [LENGTH_WIDTH-1:0] erem_q, erem_d;
  logic [LENGTH_WIDTH-1:0] acc_q, acc_d;
  logic [LENGTH_WIDTH-1:0] cur_q, cur_d;
  logic [2:0]              left_q, left_d;
  logic [15:0]             cnt_q, cnt_d;
  logic                    kind_q, kind_d;
  logic                    err_q, err_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      orem_q  <= '0;
      erem_q  <= '0;
      acc_q   <= '0;
      cur_q   <= '0;
      left_q  <= '0;
      cnt_q   <= '0;
      kind_q  <= 1'b0;
      err_q   <= 1'b0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      orem_q  <= orem_d;
      erem_q  <= erem_d;
      acc_q   <= acc_d;
      cur_q   <= cur_d;
      left_q  <= left_d;
      cnt_q   <= cnt_d;
      kind_q  <= kind_d;
      err_q   <= err_d;
    end
  end

  logic [7:0]                b;
  logic [5:0]                short_len;
  logic                      is_short;
  logic [3:0]                n;
  logic [3:0]                limit;
  logic [LENGTH_WIDTH+7:0]   acc_cat;
  logic [LENGTH_WIDTH-1:0]   acc_shift;
  logic [LENGTH_WIDTH-1:0]   orem_dec;

  assign b         = req_i.data_byte;
  assign short_len = b[5:0];
  assign is_short  = short_len <= ShortMax;
  assign n         = 4'(short_len - ShortMax);
  assign limit     = ({1'b0, max_len_bytes_i} < LenBytesW) ? {1'b0, max_len_bytes_i} : LenBytesW;
  assign acc_cat   = {acc_q, b};
  assign acc_shift = acc_cat[LENGTH_WIDTH-1:0];
  assign orem_dec  = orem_q - 1'b1;

  role_e                   role;
  logic                    o_list, o_first, o_last, o_done;
  logic [LENGTH_WIDTH-1:0] o_len;
  logic [15:0]             idx;
  logic                    do_raise, do_finish, do_known, known_kind;
  logic [LENGTH_WIDTH-1:0] known_len;

  always_comb begin
    phase_d    = phase_q;
    orem_d     = orem_q;
    erem_d     = erem_q;
    acc_d      = acc_q;
    cur_d      = cur_q;
    left_d     = left_q;
    cnt_d      = cnt_q;
    kind_d     = kind_q;
    err_d      = err_q;
    role       = RoleBeyond;
    o_list     = 1'b0;
    o_first    = 1'b0;
    o_last     = 1'b0;
    o_done     = 1'b0;
    o_len      = '0;
    do_raise   = 1'b0;
    do_finish  = 1'b0;
    do_known   = 1'b0;
    known_kind = 1'b0;
    known_len  = '0;
    idx        = req_i.frame_start ? '0 : cnt_q;

    if (req_i.frame_start) begin
      orem_d = '0;
      erem_d = '0;
      acc_d  = '0;
      cur_d  = '0;
      left_d = '0;
      cnt_d  = '0;
      kind_d = 1'b0;
      err_d  = 1'b0;
      if (!b[7]) begin
        do_raise = 1'b1;
      end else begin
        role = RoleOuter;
        if (is_short) begin
          orem_d = LENGTH_WIDTH'(short_len);
          if (short_len == '0) begin
            o_done  = 1'b1;
            phase_d = PhDone;
          end else begin
            phase_d = PhHdr;
          end
        end else if (n > limit) begin
          do_raise = 1'b1;
        end else begin
          left_d  = n[2:0];
          phase_d = PhOuterLen;
        end
      end
    end else if (phase_q == PhError) begin
      do_raise = 1'b1;
    end else if (phase_q == PhOuterLen) begin
      role   = RoleOuter;
      acc_d  = acc_shift;
      left_d = left_q - 1'b1;
      if (left_q == 3'd1) begin
        orem_d = acc_shift;
        if (acc_shift == '0) begin
          o_done  = 1'b1;
          phase_d = PhDone;
        end else begin
          phase_d = PhHdr;
        end
      end
    end else if ((phase_q == PhHdr || phase_q == PhElemLen || phase_q == PhPayload)
                 && orem_q != '0) begin
      orem_d = orem_dec;
      unique case (phase_q)
        PhHdr: begin
          o_first = 1'b1;
          if (!b[7]) begin
            role      = RoleSingle;
            kind_d    = 1'b0;
            cur_d     = LENGTH_WIDTH'(1);
            o_len     = LENGTH_WIDTH'(1);
            do_finish = 1'b1;
          end else begin
            role   = RoleEhdr;
            kind_d = b[6];
            if (is_short) begin
              do_known   = 1'b1;
              known_len  = LENGTH_WIDTH'(short_len);
              known_kind = b[6];
            end else if (n > limit || LENGTH_WIDTH'(n) > orem_dec) begin
              do_raise = 1'b1;
            end else begin
              acc_d   = '0;
              left_d  = n[2:0];
              phase_d = PhElemLen;
            end
          end
        end
        PhElemLen: begin
          role   = RoleEhdr;
          acc_d  = acc_shift;
          left_d = left_q - 1'b1;
          if (left_q == 3'd1) begin
            do_known   = 1'b1;
            known_len  = acc_shift;
            known_kind = kind_q;
          end
        end
        default: begin
          role   = RolePay;
          o_list = kind_q;
          o_len  = cur_q;
          erem_d = erem_q - 1'b1;
          if (erem_q == LENGTH_WIDTH'(1)) begin
            do_finish = 1'b1;
          end
        end
      endcase
    end else if (phase_q != PhIdle) begin
      phase_d = PhDone;
    end

    if (do_known) begin
      cur_d = known_len;
      if (known_len > orem_dec) begin
        do_raise = 1'b1;
      end else begin
        o_list = known_kind;
        o_len  = known_len;
        if (known_len == '0) begin
          do_finish = 1'b1;
        end else begin
          erem_d  = known_len;
          phase_d = PhPayload;
        end
      end
    end

    if (do_finish) begin
      o_last = 1'b1;
      if (cnt_q != IndexMax) begin
        cnt_d = cnt_q + 1'b1;
      end
      if (orem_dec == '0) begin
        o_done  = 1'b1;
        phase_d = PhDone;
      end else begin
        phase_d = PhHdr;
      end
    end

    if (do_raise) begin
      phase_d = PhError;
      err_d   = 1'b1;
      role    = RoleErr;
      o_list  = 1'b0;
      o_first = 1'b0;
      o_last  = 1'b0;
      o_done  = 1'b0;
      o_len   = '0;
    end

    res_o.byte_role       = role;
    res_o.element_index   = idx;
    res_o.element_is_list = o_list;
    res_o.element_length  = 32'(o_len);
    res_o.element_first   = o_first;
    res_o.element_last    = o_last;
    res_o.list_done       = o_done;
    res_o.error_flag      = err_d;
    res_o.byte_echo       = b;
  end

endmodule

// ===== design/rlp_out_fifo.sv =====
module rlp_out_fifo import rlp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t data_i,
  output logic space_o,
  output logic valid_o,
  input  logic pop_i,
  output res_t data_o
);

  res_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assign space_o = cnt_q != 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_q];

endmodule
